// File: src/c8u_pkg.sv
`default_nettype none

package c8u_pkg;

  // Code pages selected by the source page register.
  localparam logic [1:0] PageCp1251 = 2'd0;
  localparam logic [1:0] PageIso    = 2'd1;
  localparam logic [1:0] PageKoi8r  = 2'd2;

  localparam int unsigned QueueDepth = 2;

  // Offsets from U+0400 for the two letters outside the main block.
  localparam logic [6:0] OffCapYo   = 7'h01;
  localparam logic [6:0] OffSmallYo = 7'h51;

  localparam logic [7:0] AsciiTop  = 8'd127;
  localparam logic [7:0] LeadLow   = 8'hD0;
  localparam logic [7:0] LeadHigh  = 8'hD1;
  localparam logic [7:0] TrailMark = 8'h80;

  // One queued item: either a single byte or a two-byte sequence.
  typedef struct packed {
    logic       two_byte;
    logic [7:0] first;
    logic [7:0] second;
  } item_t;

  // KOI8-R small letters 0xC0..0xDF as code point minus U+0410.
  function automatic logic [5:0] koi_small(input logic [4:0] idx);
    logic [5:0] v;
    unique case (idx)
      5'd0:  v = 6'h3E;  5'd1:  v = 6'h20;  5'd2:  v = 6'h21;  5'd3:  v = 6'h36;
      5'd4:  v = 6'h24;  5'd5:  v = 6'h25;  5'd6:  v = 6'h34;  5'd7:  v = 6'h23;
      5'd8:  v = 6'h35;  5'd9:  v = 6'h28;  5'd10: v = 6'h29;  5'd11: v = 6'h2A;
      5'd12: v = 6'h2B;  5'd13: v = 6'h2C;  5'd14: v = 6'h2D;  5'd15: v = 6'h2E;
      5'd16: v = 6'h2F;  5'd17: v = 6'h3F;  5'd18: v = 6'h30;  5'd19: v = 6'h31;
      5'd20: v = 6'h32;  5'd21: v = 6'h33;  5'd22: v = 6'h26;  5'd23: v = 6'h22;
      5'd24: v = 6'h3C;  5'd25: v = 6'h3B;  5'd26: v = 6'h27;  5'd27: v = 6'h38;
      5'd28: v = 6'h3D;  5'd29: v = 6'h39;  5'd30: v = 6'h37;  5'd31: v = 6'h3A;
      default: v = 6'h00;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/c8u_front.sv
`default_nettype none

module c8u_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_valid_i,
  input  wire logic [1:0]    cfg_source_page_i,
  input  wire logic [7:0]    in_byte_i,
  output logic               keep_o,
  output c8u_pkg::item_t     item_o
);

  logic [1:0] page_q;
  logic       mapped;
  logic [6:0] off;
  logic [7:0] koi_off;
  logic [5:0] koi_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q <= c8u_pkg::PageCp1251;
    end else if (cfg_valid_i) begin
      page_q <= cfg_source_page_i;
    end
  end

  assign koi_val = c8u_pkg::koi_small(in_byte_i[4:0]);

  // Capitals sit 0x20 below their small letters; the offset from U+0400 adds 0x10.
  always_comb begin
    if (in_byte_i[5]) begin
      koi_off = {2'b00, koi_val} - 8'h10;
    end else begin
      koi_off = {2'b00, koi_val} + 8'h10;
    end
  end

  always_comb begin
    mapped = 1'b0;
    off    = 7'h00;
    unique case (page_q)
      c8u_pkg::PageCp1251: begin
        if (in_byte_i == 8'd168) begin
          mapped = 1'b1;
          off    = c8u_pkg::OffCapYo;
        end else if (in_byte_i == 8'd184) begin
          mapped = 1'b1;
          off    = c8u_pkg::OffSmallYo;
        end else if (in_byte_i >= 8'd192) begin
          mapped = 1'b1;
          off    = 7'(in_byte_i - 8'd176);
        end
      end
      c8u_pkg::PageIso: begin
        if (in_byte_i == 8'd161) begin
          mapped = 1'b1;
          off    = c8u_pkg::OffCapYo;
        end else if (in_byte_i == 8'd241) begin
          mapped = 1'b1;
          off    = c8u_pkg::OffSmallYo;
        end else if (in_byte_i >= 8'd176 && in_byte_i <= 8'd239) begin
          mapped = 1'b1;
          off    = 7'(in_byte_i - 8'd160);
        end
      end
      c8u_pkg::PageKoi8r: begin
        if (in_byte_i == 8'd179) begin
          mapped = 1'b1;
          off    = c8u_pkg::OffCapYo;
        end else if (in_byte_i == 8'd163) begin
          mapped = 1'b1;
          off    = c8u_pkg::OffSmallYo;
        end else if (in_byte_i >= 8'd192) begin
          mapped = 1'b1;
          off    = koi_off[6:0];
        end
      end
      default: begin
        mapped = 1'b0;
        off    = 7'h00;
      end
    endcase
  end

  always_comb begin
    if (in_byte_i <= c8u_pkg::AsciiTop) begin
      keep_o          = 1'b1;
      item_o.two_byte = 1'b0;
      item_o.first    = in_byte_i;
      item_o.second   = in_byte_i;
    end else begin
      keep_o          = mapped;
      item_o.two_byte = 1'b1;
      item_o.first    = off[6] ? c8u_pkg::LeadHigh : c8u_pkg::LeadLow;
      item_o.second   = c8u_pkg::TrailMark | {2'b00, off[5:0]};
    end
  end

endmodule

`default_nettype wire

// File: src/c8u_queue.sv
`default_nettype none

module c8u_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire c8u_pkg::item_t   wr_item_i,
  output logic                  full_o,
  input  wire logic             rd_en_i,
  output logic                  rd_valid_o,
  output c8u_pkg::item_t        rd_item_o
);

  localparam int unsigned PtrW = $clog2(c8u_pkg::QueueDepth);
  localparam int unsigned CntW = $clog2(c8u_pkg::QueueDepth + 1);

  c8u_pkg::item_t mem_q [c8u_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o     = (count_q == CntW'(c8u_pkg::QueueDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_en_i && !full_o;
  assign do_rd      = rd_en_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(c8u_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(c8u_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/c8u_back.sv
`default_nettype none

module c8u_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_valid_i,
  input  wire c8u_pkg::item_t   q_item_i,
  output logic                  q_rd_o,
  output logic                  empty,
  input  wire logic             pop,
  output logic [7:0]            out_byte_o,
  output logic                  last_of_char_o
);

  c8u_pkg::item_t cur_q;
  logic           valid_q;
  logic           phase_q;
  logic           taken;
  logic           done;

  assign empty          = !valid_q;
  assign last_of_char_o = !cur_q.two_byte || phase_q;
  assign out_byte_o     = phase_q ? cur_q.second : cur_q.first;
  assign taken          = valid_q && pop;
  assign done           = taken && last_of_char_o;
  // Load the next item as soon as the current one has given its final byte.
  assign q_rd_o         = q_valid_i && (!valid_q || done);

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      cur_q <= q_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (q_rd_o) begin
        valid_q <= 1'b1;
        phase_q <= 1'b0;
      end else if (done) begin
        valid_q <= 1'b0;
        phase_q <= 1'b0;
      end else if (taken) begin
        phase_q <= 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/cyrillic_8bit_to_utf8_core.sv
// Transcodes 8-bit Cyrillic text (CP1251, ISO 8859-5 or KOI8-R, chosen by the
// source page register) into UTF-8, one item per ASCII or mapped input byte. ASCII
// bytes come out as one byte; mapped letters come out as a lead byte (D0 or D1)
// followed by a trail byte, with last_of_char_o set on the final byte; unmapped
// high bytes are accepted and produce nothing. The result side delivers one byte
// per cycle while pop is held, so an ASCII item takes one output byte and a Cyrillic
// letter two; that single output byte port sets the sustained rate. A two-entry
// queue separates the classifier from the byte emitter, so input is taken back to
// back until the queue fills while results wait to be popped. The configuration
// port is always ready; write it only while the block is idle.
`default_nettype none

module cyrillic_8bit_to_utf8_core (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_source_page_i,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_byte_o,
  output logic            last_of_char_o
);

  c8u_pkg::item_t cls_item, head_item;
  logic           cls_keep;
  logic           head_valid;
  logic           head_rd;

  assign cfg_ready_o = 1'b1;

  c8u_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_source_page_i (cfg_source_page_i),
    .in_byte_i         (in_byte_i),
    .keep_o            (cls_keep),
    .item_o            (cls_item)
  );

  c8u_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push && cls_keep),
    .wr_item_i  (cls_item),
    .full_o     (full),
    .rd_en_i    (head_rd),
    .rd_valid_o (head_valid),
    .rd_item_o  (head_item)
  );

  c8u_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (head_valid),
    .q_item_i       (head_item),
    .q_rd_o         (head_rd),
    .empty          (empty),
    .pop            (pop),
    .out_byte_o     (out_byte_o),
    .last_of_char_o (last_of_char_o)
  );

endmodule

`default_nettype wire

// File: src/c8u_checker.sv
`default_nettype none

module c8u_checker (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic       cfg_ready_o,
  input  wire logic [1:0] cfg_source_page_i,
  input  wire logic       push,
  input  wire logic       full,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       empty,
  input  wire logic       pop,
  input  wire logic [7:0] out_byte_o,
  input  wire logic       last_of_char_o
);

  // A lead byte must be one of the two Cyrillic lead values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !last_of_char_o) |-> (out_byte_o == 8'hD0 || out_byte_o == 8'hD1))
    else $error("lead byte is not D0 or D1");

  // Once a lead byte is taken, its trail byte follows at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_char_o) |=>
      (!empty && last_of_char_o && out_byte_o[7:6] == 2'b10))
    else $error("trail byte missing after lead byte");

  // A final byte with the top bit set is a continuation byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && last_of_char_o && out_byte_o[7]) |-> (out_byte_o[7:6] == 2'b10))
    else $error("high single byte emitted");

  // A waiting result holds while it is not popped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_of_char_o)))
    else $error("result changed while stalled");

endmodule

bind cyrillic_8bit_to_utf8_core c8u_checker u_c8u_checker (.*);

`default_nettype wire
